>>> rtl/dlws_pkg.sv
// shared types, constants and lookup tables for the distributed-lag weighted sum block
`default_nettype none

package dlws_pkg;

	localparam int unsigned NUM_REGIONS_DEF = 64;
	localparam int unsigned MAX_LAGS_DEF    = 64;

	localparam logic [31:0]        ONE_Q     = 32'h0001_0000;
	localparam logic [63:0]        ROUND_Q   = 64'd32768;
	localparam logic signed [32:0] LOG2E_Q   = 33'sd94548;
	localparam logic [31:0]        SAT_MAX   = 32'h7FFF_FFFF;
	localparam logic [31:0]        SAT_MIN   = 32'h8000_0000;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_LAG  = 1'b1;

	typedef enum logic [1:0] {
		REG_WEIGHT_MODE = 2'd0,
		REG_GLOBAL_MEAN = 2'd1,
		REG_TIME_OFFSET = 2'd2
	} cfg_reg_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RD,
		S_F1,
		S_F2,
		S_F3,
		S_W,
		S_W0,
		S_TDIV,
		S_T1,
		S_T2,
		S_T3,
		S_MAC,
		S_ACC,
		S_Q0,
		S_QDIV,
		S_QFIN,
		S_OUT
	} seq_state_t;

	// upper normal tail 1 - phi(t) at t = i/8, Q0.16
	function automatic logic [15:0] tail_q(input logic [5:0] idx);
		logic [15:0] v;
		case (idx)
			6'd0: v = 16'd32768;  6'd1: v = 16'd29508;  6'd2: v = 16'd26299;
			6'd3: v = 16'd23189;  6'd4: v = 16'd20220;  6'd5: v = 16'd17432;
			6'd6: v = 16'd14852;  6'd7: v = 16'd12503;  6'd8: v = 16'd10398;
			6'd9: v = 16'd8539;   6'd10: v = 16'd6924;  6'd11: v = 16'd5542;
			6'd12: v = 16'd4378;  6'd13: v = 16'd3413;  6'd14: v = 16'd2625;
			6'd15: v = 16'd1992;  6'd16: v = 16'd1491;  6'd17: v = 16'd1101;
			6'd18: v = 16'd801;   6'd19: v = 16'd575;   6'd20: v = 16'd407;
			6'd21: v = 16'd284;   6'd22: v = 16'd195;   6'd23: v = 16'd132;
			6'd24: v = 16'd88;    6'd25: v = 16'd58;    6'd26: v = 16'd38;
			6'd27: v = 16'd24;    6'd28: v = 16'd15;    6'd29: v = 16'd9;
			6'd30: v = 16'd6;     6'd31: v = 16'd3;     6'd32: v = 16'd2;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	// 2^(j/16) in Q2.16
	function automatic logic [17:0] pow2_q(input logic [4:0] idx);
		logic [17:0] v;
		case (idx)
			5'd0: v = 18'd65536;   5'd1: v = 18'd68438;   5'd2: v = 18'd71468;
			5'd3: v = 18'd74632;   5'd4: v = 18'd77936;   5'd5: v = 18'd81386;
			5'd6: v = 18'd84990;   5'd7: v = 18'd88752;   5'd8: v = 18'd92682;
			5'd9: v = 18'd96785;   5'd10: v = 18'd101070; 5'd11: v = 18'd105545;
			5'd12: v = 18'd110218; 5'd13: v = 18'd115098; 5'd14: v = 18'd120194;
			5'd15: v = 18'd125515; 5'd16: v = 18'd131072;
			default: v = 18'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> rtl/dlws_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module dlws_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/distributed_lag_weighted_sum_unit.sv
// top level of the distributed-lag weighted sum block
`default_nettype none

// channel   direction  handshake                 payload
// cfg       in         cfg_we                    cfg_index, cfg_data
// in        in         in_valid / in_stall       action, region_key, value, last_lag, copy_count
// out       out        out_valid / out_stall     row_value, row_copies
//
// a load item is written to the region table as it is accepted; a middle lag within the lag
// limit forms its weight and accumulates; the first lag of a row first evaluates phi or exp of x
// a last lag ends with the 32-step shared restoring divider, skipped on a zero weight sum or overflow
// the taper ratio uses the same divider step for 16 steps, unless the weight is one or zero
// all products and quotients come from one shared 33x33 multiplier and one shared divider step
// reset clears the sequencer, configuration, row state and out_valid, not the datapath registers
// or the region table; in_stall is high outside S_IDLE; out_stall only holds a finished result

module distributed_lag_weighted_sum_unit #(
	parameter int unsigned NUM_REGIONS = dlws_pkg::NUM_REGIONS_DEF,
	parameter int unsigned MAX_LAGS    = dlws_pkg::MAX_LAGS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               action,
	input  wire logic [5:0]         region_key,
	input  wire logic signed [31:0] value,
	input  wire logic               last_lag,
	input  wire logic [15:0]        copy_count,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      row_value,
	output logic [15:0]             row_copies
);

	import dlws_pkg::*;

	localparam int unsigned AW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
	localparam int unsigned LW = $clog2(MAX_LAGS + 1);
	localparam logic [LW-1:0] LAG_END    = LW'(MAX_LAGS);
	localparam logic [12:0]   REGION_END = 13'(NUM_REGIONS);

	seq_state_t state_q, state_d;

	// configuration
	logic               mode_q;
	logic signed [31:0] gmean_q, toff_q;

	// captured item
	logic               key_ok_q;
	logic signed [31:0] value_q;
	logic               last_q;
	logic [15:0]        copies_q;

	// row state
	logic [LW-1:0]      lag_q;
	logic [31:0]        rf_q, cw_q, w_q;
	logic signed [63:0] ws_q;
	logic [47:0]        wsum_q;

	// working registers
	logic signed [31:0] x_q;
	logic signed [17:0] n_q;
	logic [3:0]         j_q;
	logic [48:0]        rem_q;
	logic [31:0]        quo_q;
	logic [4:0]         cnt_q;
	logic               neg_q;
	logic [31:0]        res_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] mul_a, mul_b;

	// output register
	logic               out_valid_q;
	logic [31:0]        row_value_q;
	logic [15:0]        row_copies_q;

	logic accept, out_free, key_ok;
	logic [AW+5:0] key_ext;
	logic [31:0] ram_rdata;

	assign in_stall   = (state_q != S_IDLE);
	assign accept     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign key_ok     = ({7'd0, region_key} < REGION_END);
	assign key_ext    = {{AW{1'b0}}, region_key};
	assign out_valid  = out_valid_q;
	assign row_value  = row_value_q;
	assign row_copies = row_copies_q;

	dlws_ram #(
		.WIDTH(32),
		.DEPTH(NUM_REGIONS)
	) u_region_ram (
		.clk  (clk),
		.we   (accept && action == ACT_LOAD && key_ok),
		.waddr(key_ext[AW-1:0]),
		.wdata(value),
		.re   (accept),
		.raddr(key_ext[AW-1:0]),
		.rdata(ram_rdata)
	);

	// x = mean + time offset + region offset, saturated
	logic signed [33:0] xsum;
	logic [31:0] xsat;
	always_comb begin
		xsum = 34'(gmean_q) + 34'(toff_q) + (key_ok_q ? 34'($signed(ram_rdata)) : 34'sd0);
		if (xsum[33:31] == 3'b000 || xsum[33:31] == 3'b111) begin
			xsat = xsum[31:0];
		end else if (xsum[33]) begin
			xsat = SAT_MIN;
		end else begin
			xsat = SAT_MAX;
		end
	end

	// normal cdf by interpolated tail table
	logic [31:0] a_abs;
	logic        cdf_zero;
	logic [5:0]  t_idx;
	logic [15:0] t0, t1, t_diff, q_val;
	logic [31:0] phi;
	always_comb begin
		a_abs    = x_q[31] ? (32'd0 - x_q) : x_q;
		cdf_zero = (a_abs[31:13] >= 19'd33);
		t_idx    = a_abs[18:13];
		t0       = tail_q(t_idx);
		t1       = tail_q(t_idx + 6'd1);
		t_diff   = t0 - t1;
		q_val    = cdf_zero ? 16'd0 : (t0 - prod_q[28:13]);
		phi      = x_q[31] ? {16'd0, q_val} : (ONE_Q - {16'd0, q_val});
	end

	// exp by base-2 split and interpolated 2^(j/16)
	logic [3:0]  g_j;
	logic [17:0] p_diff, m_val;
	logic [17:0] n_neg;
	logic [31:0] exp_val;
	always_comb begin
		g_j    = prod_q[31:28];
		p_diff = pow2_q({1'b0, g_j} + 5'd1) - pow2_q({1'b0, g_j});
		m_val  = pow2_q({1'b0, j_q}) + prod_q[29:12];
		n_neg  = 18'd0 - n_q;
		if (n_q >= 18'sd15) begin
			exp_val = SAT_MAX;
		end else if (n_q >= 18'sd0) begin
			exp_val = {14'd0, m_val} << n_q[3:0];
		end else if (n_q <= -18'sd32) begin
			exp_val = 32'd0;
		end else begin
			exp_val = {14'd0, m_val} >> n_neg[4:0];
		end
	end

	// spherical taper pieces
	logic [15:0]        r_val, r3;
	logic [17:0]        r_x3;
	logic signed [19:0] tw;
	logic               taper_zero;
	always_comb begin
		r_val      = quo_q[15:0];
		r3         = prod_q[31:16];
		r_x3       = {2'd0, r_val} + {1'b0, r_val, 1'b0};
		tw         = 20'sd65536 - $signed({3'd0, r_x3[17:1]}) + $signed({5'd0, r3[15:1]});
		taper_zero = ({17'd0, rf_q} <= 49'({lag_q, 16'd0}));
	end

	// shared divider step and final-quotient setup
	logic [48:0] dvs, rem_sh, rem_nx;
	logic        ge;
	logic [63:0] dvd, mag;
	logic        dvd_neg, q_ovf;
	always_comb begin
		dvs     = (state_q == S_TDIV) ? {17'd0, rf_q} : {1'b0, wsum_q};
		rem_sh  = {rem_q[47:0], quo_q[31]};
		ge      = (rem_sh >= dvs);
		rem_nx  = ge ? (rem_sh - dvs) : rem_sh;
		dvd     = {ws_q[47:0], 16'd0};
		dvd_neg = dvd[63];
		mag     = dvd_neg ? (64'd0 - dvd) : dvd;
		q_ovf   = ({17'd0, mag[63:32]} >= {1'b0, wsum_q});
	end

	logic [31:0] q_fin;
	always_comb begin
		if (!neg_q) begin
			q_fin = quo_q[31] ? SAT_MAX : quo_q;
		end else begin
			q_fin = (quo_q > SAT_MIN) ? SAT_MIN : (32'd0 - quo_q);
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = 33'sd0;
		mul_b = 33'sd0;
		case (state_q)
			S_F1: begin
				if (mode_q) begin
					mul_a = {x_q[31], x_q};
					mul_b = LOG2E_Q;
				end else begin
					mul_a = {17'd0, t_diff};
					mul_b = {20'd0, a_abs[12:0]};
				end
			end
			S_F2: begin
				mul_a = {15'd0, p_diff};
				mul_b = {21'd0, prod_q[27:16]};
			end
			S_W: begin
				mul_a = {1'b0, cw_q};
				mul_b = {1'b0, rf_q};
			end
			S_T1: begin
				mul_a = {17'd0, r_val};
				mul_b = {17'd0, r_val};
			end
			S_T2: begin
				mul_a = {17'd0, prod_q[31:16]};
				mul_b = {17'd0, r_val};
			end
			S_MAC: begin
				mul_a = {value_q[31], value_q};
				mul_b = {1'b0, w_q};
			end
			default: begin
				mul_a = 33'sd0;
				mul_b = 33'sd0;
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && action == ACT_LAG) begin
					if (lag_q == '0) begin
						state_d = S_RD;
					end else if (lag_q < LAG_END) begin
						state_d = S_W;
					end else if (last_lag) begin
						state_d = S_Q0;
					end
				end
			end
			S_RD: state_d = S_F1;
			S_F1: state_d = S_F2;
			S_F2: state_d = mode_q ? S_F3 : S_W;
			S_F3: state_d = S_W;
			S_W: begin
				if (!mode_q) begin
					state_d = S_W0;
				end else if (lag_q == '0 || taper_zero) begin
					state_d = S_MAC;
				end else begin
					state_d = S_TDIV;
				end
			end
			S_W0: state_d = S_MAC;
			S_TDIV: state_d = (cnt_q == 5'd0) ? S_T1 : S_TDIV;
			S_T1: state_d = S_T2;
			S_T2: state_d = S_T3;
			S_T3: state_d = S_MAC;
			S_MAC: state_d = S_ACC;
			S_ACC: state_d = last_q ? S_Q0 : S_IDLE;
			S_Q0: state_d = (wsum_q == 48'd0 || q_ovf) ? S_OUT : S_QDIV;
			S_QDIV: state_d = (cnt_q == 5'd0) ? S_QFIN : S_QDIV;
			S_QFIN: state_d = S_OUT;
			S_OUT: state_d = out_free ? S_IDLE : S_OUT;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration, row state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			gmean_q     <= 32'sd0;
			toff_q      <= 32'sd0;
			lag_q       <= '0;
			rf_q        <= 32'd0;
			cw_q        <= ONE_Q;
			ws_q        <= 64'sd0;
			wsum_q      <= 48'd0;
			cnt_q       <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WEIGHT_MODE: mode_q  <= cfg_data[0];
					REG_GLOBAL_MEAN: gmean_q <= $signed(cfg_data);
					REG_TIME_OFFSET: toff_q  <= $signed(cfg_data);
					default: ;
				endcase
			end
			// a new result replaces one taken in the same cycle
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_F2: begin
					if (!mode_q) begin
						rf_q <= phi;
						cw_q <= ONE_Q;
					end
				end
				S_F3: begin
					rf_q <= exp_val;
					cw_q <= ONE_Q;
				end
				S_W: begin
					if (mode_q && lag_q != '0 && !taper_zero) begin
						cnt_q <= 5'd15;
					end
				end
				S_W0: cw_q <= 32'((prod_q[63:0] + ROUND_Q) >> 16);
				S_TDIV, S_QDIV: cnt_q <= cnt_q - 5'd1;
				S_ACC: begin
					ws_q   <= ws_q + {{14{prod_q[65]}}, prod_q[65:16]};
					wsum_q <= wsum_q + {16'd0, w_q};
					lag_q  <= lag_q + 1'b1;
				end
				S_Q0: cnt_q <= 5'd31;
				S_OUT: begin
					if (out_free) begin
						lag_q  <= '0;
						cw_q   <= ONE_Q;
						ws_q   <= 64'sd0;
						wsum_q <= 48'd0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			key_ok_q <= key_ok;
			value_q  <= value;
			last_q   <= last_lag;
			copies_q <= copy_count;
		end
		case (state_q)
			S_RD: x_q <= xsat;
			S_F2: begin
				n_q <= prod_q[49:32];
				j_q <= prod_q[31:28];
			end
			S_W: begin
				if (!mode_q) begin
					w_q <= cw_q;
				end else if (lag_q == '0) begin
					w_q <= ONE_Q;
				end else if (taper_zero) begin
					w_q <= 32'd0;
				end else begin
					rem_q <= 49'({lag_q, 16'd0});
					quo_q <= 32'd0;
				end
			end
			S_TDIV, S_QDIV: begin
				rem_q <= rem_nx;
				quo_q <= {quo_q[30:0], ge};
			end
			S_T3: w_q <= tw[19] ? 32'd0 : {12'd0, tw};
			S_Q0: begin
				neg_q <= dvd_neg;
				rem_q <= {17'd0, mag[63:32]};
				quo_q <= mag[31:0];
				if (wsum_q == 48'd0) begin
					res_q <= 32'd0;
				end else begin
					res_q <= dvd_neg ? SAT_MIN : SAT_MAX;
				end
			end
			S_QFIN: res_q <= q_fin;
			S_OUT: begin
				if (out_free) begin
					row_value_q  <= res_q;
					row_copies_q <= copies_q;
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result appeared outside the output step");

	a_wsum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Q0) |-> (wsum_q >= 48'd65536))
		else $error("row ends without lag zero weight");

	a_lag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lag_q <= LAG_END)
		else $error("lag counter past limit");

	a_taper_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_T1) |-> (quo_q[31:16] == 16'd0))
		else $error("taper ratio wider than 16 bits");
`endif

endmodule

`default_nettype wire

>>> tb/distributed_lag_weighted_sum_unit_tb.sv
// self-checking testbench for the distributed-lag weighted sum block
`timescale 1ns / 1ps

module distributed_lag_weighted_sum_unit_tb;
	import dlws_pkg::*;

	// row result as the block should report it
	typedef struct {
		logic signed [31:0] mean;
		logic [15:0]        copies;
	} row_result_t;

	// predicted row means and the running comparison against the block
	class row_scoreboard;
		// predictor state, mirrors the block
		logic              mode;
		logic signed [31:0] mean_reg;
		logic signed [31:0] period_reg;
		logic signed [31:0] offsets [64];
		int unsigned        lag_count;
		longint unsigned    row_factor;
		longint unsigned    cur_weight;
		longint             wsum;
		longint             wtot;
		row_result_t        pending [$];
		int                 mismatches;

		function void reset_state();
			mode = 0; mean_reg = 0; period_reg = 0;
			foreach (offsets[i]) offsets[i] = 0;
			row_factor = 0; clear_row();
			pending.delete(); mismatches = 0;
		endfunction

		function void clear_row();
			lag_count = 0; cur_weight = 65536; wsum = 0; wtot = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [31:0] d);
			case (idx)
				REG_WEIGHT_MODE: mode = d[0];
				REG_GLOBAL_MEAN: mean_reg = d;
				REG_TIME_OFFSET: period_reg = d;
				default: ;
			endcase
		endfunction

		// floor division by 2^s for signed values
		function longint fshift(longint v, int s);
			return v >>> s;
		endfunction

		function longint unsigned phi_of(logic signed [31:0] x);
			longint unsigned a, i, f, q, ti, tn;
			a = (x < 0) ? (64'h1_0000_0000 - {32'd0, x}) & 64'hFFFF_FFFF : x;
			i = a >> 13; f = a & 8191;
			if (i >= 33) q = 0;
			else begin
				ti = tail_q(i[5:0]); tn = tail_q(i[5:0] + 6'd1);
				q = ti - (((ti - tn) * f) >> 13);
			end
			return (x >= 0) ? 65536 - q : q;
		endfunction

		function longint unsigned exp_of(logic signed [31:0] x);
			longint y, n, g, j, h, m;
			y = fshift(longint'(x) * 94548, 16);
			n = fshift(y, 16);
			g = y & 16'hFFFF;
			j = g >> 12; h = g & 4095;
			m = pow2_q(j[4:0]) + (((pow2_q(j[4:0] + 5'd1) - pow2_q(j[4:0])) * h) >> 12);
			if (n >= 15) return 32'h7FFF_FFFF;
			if (n >= 0) return (m << n) & 64'hFFFF_FFFF;
			if (n <= -32) return 0;
			return m >> (-n);
		endfunction

		function longint unsigned taper(longint unsigned k, longint unsigned e);
			longint unsigned r, r3;
			longint w;
			if (k == 0) return 65536;
			if (e <= (k << 16)) return 0;
			r = (k << 32) / e;
			r3 = (((r * r) >> 16) * r) >> 16;
			w = 65536 - longint'((3 * r) >> 1) + longint'(r3 >> 1);
			return (w < 0) ? 0 : w;
		endfunction

		// note one accepted input item
		function void note_item(logic act, logic [5:0] key, logic signed [31:0] v,
				logic last, logic [15:0] cc);
			longint sx, q;
			longint unsigned w;
			row_result_t r;
			if (act == ACT_LOAD) begin
				offsets[key] = v;
				return;
			end
			if (lag_count == 0) begin
				sx = longint'(mean_reg) + longint'(period_reg) + longint'(offsets[key]);
				if (sx > 64'sh7FFF_FFFF) sx = 64'sh7FFF_FFFF;
				if (sx < -64'sh8000_0000) sx = -64'sh8000_0000;
				row_factor = (mode == 0) ? phi_of(sx[31:0]) : exp_of(sx[31:0]);
				cur_weight = 65536;
			end
			if (lag_count < 64) begin
				if (mode == 0) begin
					w = cur_weight;
					// the weight register is 32 bits wide
					cur_weight = ((cur_weight * row_factor + 32768) >> 16) & 64'hFFFF_FFFF;
				end else
					w = taper(lag_count, row_factor);
				wsum += fshift(longint'(v) * longint'(w), 16);
				wtot += longint'(w);
				lag_count++;
			end
			if (!last) return;
			q = (wtot != 0) ? (wsum * 65536) / wtot : 0;
			if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
			if (q < -64'sh8000_0000) q = -64'sh8000_0000;
			r.mean = q[31:0];
			r.copies = cc;
			pending.push_back(r);
			clear_row();
		endfunction

		// compare one accepted result with the oldest prediction
		function void check_result(logic signed [31:0] mean, logic [15:0] copies);
			row_result_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected row result mean=%0d copies=%0d", mean, copies);
				return;
			end
			e = pending.pop_front();
			if (e.mean !== mean || e.copies !== copies) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row mismatch: mean exp %0d got %0d, copies exp %0d got %0d",
						e.mean, mean, e.copies, copies);
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic [1:0]         cfg_index = 0;
	logic [31:0]        cfg_data = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic               action = 0;
	logic [5:0]         region_key = 0;
	logic signed [31:0] value = 0;
	logic               last_lag = 0;
	logic [15:0]        copy_count = 0;
	logic               out_valid;
	logic               out_stall = 0;
	logic signed [31:0] row_value;
	logic [15:0]        row_copies;

	distributed_lag_weighted_sum_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .region_key(region_key), .value(value),
		.last_lag(last_lag), .copy_count(copy_count),
		.out_valid(out_valid), .out_stall(out_stall),
		.row_value(row_value), .row_copies(row_copies)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	row_scoreboard sb = new();

	// idle and stall percentages, changed per phase
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_cycles = 0;    // long receiver hold-off when nonzero
	bit          written [64];       // region entries loaded so far
	longint      cycle_count = 0;

	// receiver: random stall, or a long hold-off counted here
	always @(posedge clk) begin
		if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	// results are checked where the handshake completes
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(row_value, row_copies);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, d);
	endtask

	// offer one item, hold it until taken; valid stays up between back-to-back items
	task automatic send_item(logic act, logic [5:0] key, logic signed [31:0] v,
			logic last, logic [15:0] cc);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; action <= act; region_key <= key; value <= v;
		last_lag <= last; copy_count <= cc;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(act, key, v, last, cc);
	endtask

	task automatic go_idle();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		// a non-final lag may still be in flight
		repeat (60) @(posedge clk);
	endtask

	task automatic load_region(logic [5:0] key, logic signed [31:0] v);
		send_item(ACT_LOAD, key, v, 1'($urandom_range(1)), 16'($urandom));
		written[key] = 1;
	endtask

	function automatic logic [5:0] known_key();
		logic [5:0] k;
		do k = 6'($urandom_range(63)); while (!written[k]);
		return k;
	endfunction

	// random offset: mostly small so weights stay interesting
	function automatic logic signed [31:0] rand_offset();
		case ($urandom_range(9))
			0: return $urandom;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh8000_0000;
			default: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
		endcase
	endfunction

	// one row of random length; short rows dominate, a few overrun the lag limit
	task automatic send_row(ref int count);
		int unsigned len;
		logic [5:0] k;
		len = ($urandom_range(19) == 0) ? $urandom_range(64, 70) : $urandom_range(1, 6);
		k = known_key();
		for (int unsigned i = 0; i < len; i++) begin
			// occasional table update inside a row
			if ($urandom_range(29) == 0) begin
				load_region(6'($urandom_range(63)), rand_offset()); count++;
			end
			send_item(ACT_LAG, (i == 0) ? k : 6'($urandom), $urandom,
				i == len - 1, 16'($urandom));
			count++;
		end
	endtask

	initial begin
		int count;
		foreach (written[i]) written[i] = 0;
		sb.reset_state();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: table extremes, both modes, copy count extremes
		load_region(0, 0);
		load_region(63, 32'sh7FFF_FFFF);
		load_region(1, 32'sh8000_0000);
		load_region(2, 32'sh0001_0000);
		send_item(ACT_LAG, 0, 32'sh7FFF_FFFF, 0, 0);
		send_item(ACT_LAG, 6'd5, 32'sh8000_0000, 1, 16'hFFFF);
		send_item(ACT_LAG, 63, 32'sh8000_0000, 1, 0);
		send_item(ACT_LAG, 1, -32'sd65536, 0, 0);
		load_region(3, -32'sd131072);       // table update inside a row
		send_item(ACT_LAG, 2, 32'sh7FFF_FFFF, 1, 16'h5A5A);
		go_idle();
		write_reg(REG_WEIGHT_MODE, 1);
		write_reg(REG_GLOBAL_MEAN, 32'sh0002_0000);
		write_reg(REG_TIME_OFFSET, 32'sh0001_8000);
		for (int i = 0; i < 6; i++)
			send_item(ACT_LAG, 3, (i & 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF, i == 5, 16'hA5A5);
		send_item(ACT_LAG, 63, 32'sd12345, 1, 1);
		send_item(ACT_LAG, 1, 32'sd12345, 0, 1);
		go_idle();
		write_reg(REG_WEIGHT_MODE, 0);    // mode change inside a row
		send_item(ACT_LAG, 0, 32'sd99, 1, 2);
		go_idle();
		write_reg(REG_GLOBAL_MEAN, 32'sh8000_0000);
		write_reg(REG_TIME_OFFSET, 32'sh8000_0000);
		send_item(ACT_LAG, 0, 32'sd7, 1, 3);
		go_idle();

		// random phases: idle/stall mixes, with config changes between them
		count = 0;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 71; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 71; end
				default: begin send_idle_pct = 15; stall_pct = 15; end
			endcase
			write_reg(REG_WEIGHT_MODE, 32'(phase[0] ^ phase[2]));
			write_reg(REG_GLOBAL_MEAN, (phase == 7) ? 32'sh7FFF_FFFF : rand_offset());
			write_reg(REG_TIME_OFFSET, (phase == 7) ? 32'sh7FFF_FFFF : rand_offset());
			if (phase == 2) hold_cycles = 600;   // block fills and stalls its input
			for (int i = 0; i < 8; i++) begin
				load_region(6'($urandom_range(63)), rand_offset()); count++;
			end
			while (count < 170 * (phase + 1)) begin
				if ($urandom_range(9) == 0) begin
					load_region(6'($urandom_range(63)), rand_offset()); count++;
				end else
					send_row(count);
			end
			// sender waits until all rows have come back
			go_idle();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> distributed_lag_weighted_sum_unit.f
rtl/dlws_pkg.sv
rtl/dlws_ram.sv
rtl/distributed_lag_weighted_sum_unit.sv
tb/distributed_lag_weighted_sum_unit_tb.sv
